FILE: design/dcfp_pkg.sv
package dcfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    // 8-bit sum of the two header bytes, the seed of the running checksum
    localparam logic [7:0] HDR_SUM    = 8'hFF;

    localparam int FLAG_EN_BIT   = 0;
    localparam int FLAG_STOP_BIT = 1;

    typedef enum logic {
        STATUS_OK  = 1'b0,
        STATUS_BAD = 1'b1
    } t_status;

    // byte position within a frame; the count of frame bytes held so far
    typedef enum logic [2:0] {
        POS_HUNT  = 3'd0,
        POS_HDR2  = 3'd1,
        POS_SEQ   = 3'd2,
        POS_SPEED = 3'd3,
        POS_STEER = 3'd4,
        POS_FLAGS = 3'd5,
        POS_CSUM  = 3'd6
    } t_pos;

    // one checked frame, front to back
    typedef struct packed {
        logic       match;
        logic [7:0] seq;
        logic [7:0] speed;
        logic [7:0] steer;
        logic [7:0] flags;
    } t_check;

endpackage

FILE: design/dcfp_if.sv
interface dcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dcfp_out_if;
    logic              valid;
    logic              ready;
    logic              frame_status;
    logic [7:0]        cmd_sequence;
    logic signed [7:0] cmd_speed_raw;
    logic signed [7:0] cmd_steer_raw;
    logic [7:0]        cmd_flag_bits;
    logic signed [7:0] drive_speed;
    logic              steer_apply;

    modport source (output valid, output frame_status, output cmd_sequence,
                    output cmd_speed_raw, output cmd_steer_raw, output cmd_flag_bits,
                    output drive_speed, output steer_apply, input ready);
    modport sink   (input valid, input frame_status, input cmd_sequence,
                    input cmd_speed_raw, input cmd_steer_raw, input cmd_flag_bits,
                    input drive_speed, input steer_apply, output ready);
endinterface

FILE: design/dcfp_front.sv
module dcfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_ready,
    input  logic            i_q_full,
    output logic            o_push,
    output dcfp_pkg::t_check o_check
);

    dcfp_pkg::t_pos r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_seq, r_speed, r_steer, r_flags;
    logic       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= dcfp_pkg::POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum <= n_sum;
            if (r_pos == dcfp_pkg::POS_SEQ)   r_seq   <= i_byte;
            if (r_pos == dcfp_pkg::POS_SPEED) r_speed <= i_byte;
            if (r_pos == dcfp_pkg::POS_STEER) r_steer <= i_byte;
            if (r_pos == dcfp_pkg::POS_FLAGS) r_flags <= i_byte;
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum + i_byte;
        o_push = 1'b0;
        if (accept) begin
            case (r_pos)
                dcfp_pkg::POS_HUNT: begin
                    if (i_byte == dcfp_pkg::HDR_FIRST) n_pos = dcfp_pkg::POS_HDR2;
                end
                dcfp_pkg::POS_HDR2: begin
                    // mismatch drops back to hunting; the byte is not rechecked
                    n_pos = (i_byte == dcfp_pkg::HDR_SECOND) ? dcfp_pkg::POS_SEQ
                                                              : dcfp_pkg::POS_HUNT;
                    n_sum = dcfp_pkg::HDR_SUM;
                end
                dcfp_pkg::POS_SEQ:   n_pos = dcfp_pkg::POS_SPEED;
                dcfp_pkg::POS_SPEED: n_pos = dcfp_pkg::POS_STEER;
                dcfp_pkg::POS_STEER: n_pos = dcfp_pkg::POS_FLAGS;
                dcfp_pkg::POS_FLAGS: n_pos = dcfp_pkg::POS_CSUM;
                dcfp_pkg::POS_CSUM: begin
                    n_pos  = dcfp_pkg::POS_HUNT;
                    o_push = 1'b1;
                end
                default: n_pos = dcfp_pkg::POS_HUNT;
            endcase
        end
    end

    always_comb begin
        o_check.match = (r_sum == i_byte);
        o_check.seq   = r_seq;
        o_check.speed = r_speed;
        o_check.steer = r_steer;
        o_check.flags = r_flags;
    end

endmodule

FILE: design/dcfp_queue.sv
module dcfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dcfp_pkg::t_check i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output dcfp_pkg::t_check o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dcfp_pkg::t_check r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: design/dcfp_back.sv
module dcfp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  dcfp_pkg::t_check  i_check,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_status,
    output logic [7:0]        o_seq,
    output logic signed [7:0] o_speed,
    output logic signed [7:0] o_steer,
    output logic [7:0]        o_flags,
    output logic signed [7:0] o_drive,
    output logic              o_apply
);

    logic       r_valid;
    logic       r_status;
    logic [7:0] r_seq, r_speed, r_steer, r_flags;
    logic       go;

    // the output slot frees when empty or taken this cycle
    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= dcfp_pkg::STATUS_OK;
            r_seq    <= '0;
            r_speed  <= '0;
            r_steer  <= '0;
            r_flags  <= '0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_status <= i_check.match ? dcfp_pkg::STATUS_OK : dcfp_pkg::STATUS_BAD;
            if (i_check.match) begin
                r_seq   <= i_check.seq;
                r_speed <= i_check.speed;
                r_steer <= i_check.steer;
                r_flags <= i_check.flags;
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign go       = r_flags[dcfp_pkg::FLAG_EN_BIT] && !r_flags[dcfp_pkg::FLAG_STOP_BIT];
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_seq    = r_seq;
    assign o_speed  = r_speed;
    assign o_steer  = r_steer;
    assign o_flags  = r_flags;
    assign o_drive  = go ? r_speed : 8'sd0;
    assign o_apply  = go;

endmodule

FILE: design/drive_command_frame_parser_top.sv
// channel   dir  handshake        payload
// i_rx      in   valid / ready    rx_byte[7:0]
// o_frame   out  valid / ready    frame_status, cmd_sequence, cmd_speed_raw,
//                                 cmd_steer_raw, cmd_flag_bits, drive_speed, steer_apply
//
// One byte per cycle is taken while the check queue has room; a result passes
// through the queue, then the output register, after its checksum byte.
// The front keeps a running 8-bit sum, so the checksum compare is one add deep.
// Reset (i_rst_n low, synchronous) returns to header hunting, clears the stored
// command and the queue. An output stall backs up the queue; i_rx.ready drops
// only when QUEUE_DEPTH checked frames are waiting.
module drive_command_frame_parser_top #(
    parameter int QUEUE_DEPTH = 2  // checked frames buffered, 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcfp_in_if.sink     i_rx,
    dcfp_out_if.source  o_frame
);

    logic             q_full;
    logic             push;
    logic             pop;
    logic             q_valid;
    dcfp_pkg::t_check push_check;
    dcfp_pkg::t_check pop_check;

    // front: header hunt, byte collection, running checksum
    dcfp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_rx.valid),
        .i_byte   (i_rx.rx_byte),
        .o_ready  (i_rx.ready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_check  (push_check)
    );

    // checked frames waiting for the back end
    dcfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_check),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_check)
    );

    // back: command store, drive gating, output register
    dcfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_check   (pop_check),
        .o_pop     (pop),
        .o_valid   (o_frame.valid),
        .i_ready   (o_frame.ready),
        .o_status  (o_frame.frame_status),
        .o_seq     (o_frame.cmd_sequence),
        .o_speed   (o_frame.cmd_speed_raw),
        .o_steer   (o_frame.cmd_steer_raw),
        .o_flags   (o_frame.cmd_flag_bits),
        .o_drive   (o_frame.drive_speed),
        .o_apply   (o_frame.steer_apply)
    );

endmodule

FILE: design/dcfp_checker.sv
module dcfp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [7:0]        i_flags,
    input logic signed [7:0] i_speed,
    input logic signed [7:0] i_drive,
    input logic              i_apply,
    input logic              i_status
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");

    // steer gating follows the shown flags
    a_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_apply == (i_flags[dcfp_pkg::FLAG_EN_BIT]
                                 && !i_flags[dcfp_pkg::FLAG_STOP_BIT])))
        else $error("steer_apply disagrees with flags");

    // drive speed is the stored speed when applied, else zero
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_apply ? (i_drive == i_speed) : (i_drive == 8'sd0)))
        else $error("drive_speed gating wrong");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_flags)))
        else $error("stalled result changed");

endmodule

bind drive_command_frame_parser_top dcfp_checker u_dcfp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_frame.valid),
    .i_ready  (o_frame.ready),
    .i_flags  (o_frame.cmd_flag_bits),
    .i_speed  (o_frame.cmd_speed_raw),
    .i_drive  (o_frame.drive_speed),
    .i_apply  (o_frame.steer_apply),
    .i_status (o_frame.frame_status)
);
